// File: design/assert_macros.svh
// Assertion macros shared by the tag allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/itag_pkg.sv
// Types and constants for the I/O tag allocator.
package itag_pkg;

	localparam int HW_SLOTS    = 64;
	localparam int SECTOR_BITS = 9;
	localparam int PAGE_BYTES  = 4096;
	localparam int QDEPTH      = 2;
	localparam int TAG_W       = 6;
	localparam int CFG_W       = 7;

	// request kinds
	localparam logic REQ_ISSUE    = 1'b0;
	localparam logic REQ_COMPLETE = 1'b1;

	// response status codes
	localparam logic [2:0] ST_ISSUED     = 3'd0;
	localparam logic [2:0] ST_NO_SLOT    = 3'd1;
	localparam logic [2:0] ST_MISALIGNED = 3'd2;
	localparam logic [2:0] ST_DONE_OK    = 3'd3;
	localparam logic [2:0] ST_DONE_FAIL  = 3'd4;
	localparam logic [2:0] ST_IDLE_SLOT  = 3'd5;

	typedef struct packed {
		logic               req_type;
		logic [30:0]        file_handle;
		logic               is_write;
		logic [54:0]        first_sector;
		logic [54:0]        end_sector;
		logic [63:0]        buffer_address;
		logic [31:0]        request_context;
		logic [TAG_W-1:0]   completion_tag;
		logic signed [63:0] completion_result;
	} itag_req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [TAG_W-1:0] slot_tag;
		logic [63:0]      byte_offset;
		logic [63:0]      byte_count;
		logic [30:0]      handle_out;
		logic             write_out;
		logic [63:0]      buffer_out;
		logic [31:0]      returned_context;
	} itag_rsp_t;

	// classified request, as queued between front and back
	typedef enum logic [1:0] {
		CMD_ISSUE,
		CMD_MISALIGNED,
		CMD_COMPLETE
	} itag_kind_t;

	typedef struct packed {
		itag_kind_t       kind;
		logic [TAG_W-1:0] tag;
		logic [63:0]      byte_offset;
		logic [63:0]      byte_count;
		logic [30:0]      handle;
		logic             write;
		logic [63:0]      buffer;
		logic [31:0]      context_val;
		logic [63:0]      result;
	} itag_cmd_t;

endpackage

// File: design/io_tag_allocator.sv
// A request passes through the request queue, stage 1 and the output register before its response shows.
// Throughput: one request per cycle unless the response side stalls, set by the single free-map update per cycle.
// Completions read the slot memories at one port; the compare is in the next stage.
// Reset: all active slots free, active count SLOTS capped at 64; slot memories are not cleared.
// A configuration write makes every active slot free, dropping outstanding tags.
module io_tag_allocator #(
	parameter int SLOTS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [itag_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  itag_pkg::itag_req_t        req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output itag_pkg::itag_rsp_t        rsp
);
	import itag_pkg::*;

	itag_cmd_t cmd;
	itag_cmd_t q_data;
	logic      q_full;
	logic      q_empty;
	logic      q_pop;

	assign req_stall = q_full;

	itag_front u_front (
		.req (req),
		.cmd (cmd)
	);

	itag_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (req_valid && !q_full),
		.push_data (cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	itag_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// File: design/itag_front.sv
// Front end: classifies a request and precomputes the descriptor byte fields.
module itag_front (
	input  itag_pkg::itag_req_t req,
	output itag_pkg::itag_cmd_t cmd
);
	import itag_pkg::*;

	logic misaligned;
	logic [63:0] span;

	// page alignment: low address bits must be zero
	assign misaligned = (req.buffer_address & 64'(PAGE_BYTES - 1)) != 64'd0;
	// sector span wraps modulo 2^64
	assign span = 64'(req.end_sector) - 64'(req.first_sector);

	always_comb begin
		cmd = '0;
		cmd.tag         = req.completion_tag;
		cmd.result      = req.completion_result;
		cmd.handle      = req.file_handle;
		cmd.write       = req.is_write;
		cmd.buffer      = req.buffer_address;
		cmd.context_val = req.request_context;
		cmd.byte_offset = 64'(req.first_sector) << SECTOR_BITS;
		cmd.byte_count  = span << SECTOR_BITS;
		if (req.req_type == REQ_COMPLETE) begin
			cmd.kind = CMD_COMPLETE;
		end else if (misaligned) begin
			cmd.kind = CMD_MISALIGNED;
		end else begin
			cmd.kind = CMD_ISSUE;
		end
	end

endmodule

// File: design/itag_queue.sv
// Short FIFO of classified requests between front and back.
`include "assert_macros.svh"

module itag_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  itag_pkg::itag_cmd_t push_data,
	output logic                full,
	input  logic                pop,
	output itag_pkg::itag_cmd_t pop_data,
	output logic                empty
);
	import itag_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	itag_cmd_t        entry_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full     = count_q == (PTR_W+1)'(QDEPTH);
	assign empty    = count_q == '0;
	assign pop_data = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	`ASSERT_IMPLIES(a_pop_nonempty, pop, !empty, "pop from empty request queue")

endmodule

// File: design/itag_back.sv
// Back end: free map, slot memories and response pipeline.
`include "assert_macros.svh"

module itag_back #(
	parameter int SLOTS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [itag_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         q_empty,
	input  itag_pkg::itag_cmd_t          q_data,
	output logic                         q_pop,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output itag_pkg::itag_rsp_t          rsp
);
	import itag_pkg::*;

	localparam int NSLOT = (SLOTS < HW_SLOTS) ? SLOTS : HW_SLOTS;
	localparam int IDXW  = (NSLOT > 1) ? $clog2(NSLOT) : 1;

	// clamp the programmed count to 1..NSLOT
	function automatic logic [CFG_W-1:0] clamp_limit(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0) r = CFG_W'(1);
		else if (v > CFG_W'(NSLOT)) r = CFG_W'(NSLOT);
		return r;
	endfunction

	function automatic logic [NSLOT-1:0] mask_of(input logic [CFG_W-1:0] lim);
		logic [NSLOT-1:0] m;
		for (int i = 0; i < NSLOT; i++) m[i] = CFG_W'(i) < lim;
		return m;
	endfunction

	logic [CFG_W-1:0] limit_q;
	logic [NSLOT-1:0] free_q;
	logic [31:0]      ctx_mem [NSLOT];
	logic [63:0]      exp_mem [NSLOT];

	logic             found;
	logic [IDXW-1:0]  alloc_idx;
	logic             tag_ok;
	logic [IDXW-1:0]  tag_idx;
	logic             busy;
	logic             issue_commit;
	logic             cmpl_commit;
	logic             out_free;
	logic             s1_adv;
	itag_rsp_t        rsp_d;
	logic             cmp_d;
	itag_rsp_t        rsp_fin;

	logic             valid_s1;
	itag_rsp_t        rsp_s1;
	logic             cmp_s1;
	logic [63:0]      result_s1;
	logic [31:0]      ctx_rd_s1;
	logic [63:0]      exp_rd_s1;

	logic             rsp_valid_q;
	itag_rsp_t        rsp_q;

	// lowest free slot
	always_comb begin
		found     = 1'b0;
		alloc_idx = '0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				found     = 1'b1;
				alloc_idx = IDXW'(i);
			end
		end
	end

	// completion tag lookup
	assign tag_ok  = CFG_W'(q_data.tag) < limit_q;
	assign tag_idx = q_data.tag[IDXW-1:0];
	assign busy    = tag_ok && !free_q[tag_idx];

	// flow control
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign s1_adv   = valid_s1 && out_free;
	assign q_pop    = !q_empty && (!valid_s1 || out_free);

	assign issue_commit = q_pop && (q_data.kind == CMD_ISSUE) && found;
	assign cmpl_commit  = q_pop && (q_data.kind == CMD_COMPLETE) && busy;

	// slot count and free map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= CFG_W'(NSLOT);
			free_q  <= mask_of(CFG_W'(NSLOT));
		end else if (cfg_we) begin
			limit_q <= clamp_limit(cfg_wdata);
			free_q  <= mask_of(clamp_limit(cfg_wdata));
		end else begin
			if (issue_commit) free_q[alloc_idx] <= 1'b0;
			if (cmpl_commit)  free_q[tag_idx]   <= 1'b1;
		end
	end

	// slot memories, registered read on completion
	always_ff @(posedge clk) begin
		if (issue_commit) begin
			ctx_mem[alloc_idx] <= q_data.context_val;
			exp_mem[alloc_idx] <= q_data.byte_count;
		end
		if (cmpl_commit) begin
			ctx_rd_s1 <= ctx_mem[tag_idx];
			exp_rd_s1 <= exp_mem[tag_idx];
		end
	end

	// response decode
	always_comb begin
		rsp_d = '0;
		cmp_d = 1'b0;
		unique case (q_data.kind)
			CMD_ISSUE: begin
				if (found) begin
					rsp_d.status      = ST_ISSUED;
					rsp_d.slot_tag    = TAG_W'(alloc_idx);
					rsp_d.byte_offset = q_data.byte_offset;
					rsp_d.byte_count  = q_data.byte_count;
					rsp_d.handle_out  = q_data.handle;
					rsp_d.write_out   = q_data.write;
					rsp_d.buffer_out  = q_data.buffer;
				end else begin
					rsp_d.status = ST_NO_SLOT;
				end
			end
			CMD_MISALIGNED: begin
				rsp_d.status = ST_MISALIGNED;
			end
			CMD_COMPLETE: begin
				rsp_d.slot_tag = q_data.tag;
				if (busy) cmp_d = 1'b1;
				else rsp_d.status = ST_IDLE_SLOT;
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (q_pop) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rsp_s1    <= rsp_d;
			cmp_s1    <= cmp_d;
			result_s1 <= q_data.result;
		end
	end

	// completion outcome merged into the stage 1 response
	always_comb begin
		rsp_fin = rsp_s1;
		if (cmp_s1) begin
			rsp_fin.status           = (result_s1 == exp_rd_s1) ? ST_DONE_OK : ST_DONE_FAIL;
			rsp_fin.returned_context = ctx_rd_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q <= rsp_fin;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_ALWAYS(a_free_in_range, (free_q & ~mask_of(limit_q)) == '0, "free slot beyond limit")
	`ASSERT_IMPLIES(a_issue_free, issue_commit, free_q[alloc_idx], "allocated a busy slot")
	`ASSERT_NEXT(a_cmpl_frees, cmpl_commit && !cfg_we, free_q[$past(tag_idx)], "slot not freed")

endmodule

// File: tb/io_tag_allocator_test.sv
// Self-checking testbench for the I/O tag allocator: directed, limit, backpressure, random.
module io_tag_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import itag_pkg::*;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int HOLD_CYCLES     = 80;
	localparam int DRAIN_CYCLES    = 6;
	localparam int MAX_PRINTS      = 40;
	localparam int PHASE_REQUESTS  = 225;

	typedef enum {STALL_LIGHT, STALL_HEAVY, STALL_PATTERN, STALL_NONE} stall_style_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	itag_req_t        req = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	itag_rsp_t        rsp;

	// shadow of the tag table
	logic [CFG_W-1:0] active_setting = 7'd64;
	logic [63:0]      free_slots = '1;
	logic [31:0]      slot_ctx [HW_SLOTS] = '{default: '0};
	logic [63:0]      slot_bytes [HW_SLOTS] = '{default: '0};
	itag_rsp_t        rsp_due[$];

	int unsigned  err_count = 0;
	int unsigned  idle_cycles = 0;
	int unsigned  beat = 0;
	int           hold_left = 0;
	logic         hold_request = 1'b0;
	logic         hold_ack = 1'b0;
	stall_style_t stall_mode = STALL_LIGHT;
	bit           gaps_on = 1'b1;
	int           burst_left = 0;

	io_tag_allocator #(.SLOTS(64)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Slot count in effect: register value clamped to 1..64
	function automatic int unsigned usable_slots();
		int unsigned n;
		n = 32'(active_setting);
		if (n < 1) n = 1;
		if (n > HW_SLOTS) n = HW_SLOTS;
		return n;
	endfunction

	function automatic logic [63:0] slot_mask();
		int unsigned n;
		n = usable_slots();
		if (n >= 64) return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	// Expected response for one request; updates the shadow table
	function automatic itag_rsp_t resolve_tag_request(itag_req_t r);
		itag_rsp_t   o;
		int unsigned n;
		int          slot;
		int          i;
		o = '0;
		n = usable_slots();
		if (r.req_type == REQ_ISSUE) begin
			if (r.buffer_address % 64'(PAGE_BYTES) != 64'd0) begin
				o.status = ST_MISALIGNED;
				return o;
			end
			slot = -1;
			for (i = int'(n) - 1; i >= 0; i--) begin
				if (free_slots[i]) slot = i;
			end
			if (slot < 0) begin
				o.status = ST_NO_SLOT;
				return o;
			end
			free_slots[slot] = 1'b0;
			slot_ctx[slot] = r.request_context;
			slot_bytes[slot] = (64'(r.end_sector) - 64'(r.first_sector)) << SECTOR_BITS;
			o.status = ST_ISSUED;
			o.slot_tag = TAG_W'(slot);
			o.byte_offset = 64'(r.first_sector) << SECTOR_BITS;
			o.byte_count = slot_bytes[slot];
			o.handle_out = r.file_handle;
			o.write_out = r.is_write;
			o.buffer_out = r.buffer_address;
		end else begin
			o.slot_tag = r.completion_tag;
			if (int'(r.completion_tag) >= int'(n) || free_slots[r.completion_tag]) begin
				o.status = ST_IDLE_SLOT;
			end else begin
				free_slots[r.completion_tag] = 1'b1;
				o.status = ($unsigned(r.completion_result) == slot_bytes[r.completion_tag]) ?
					ST_DONE_OK : ST_DONE_FAIL;
				o.returned_context = slot_ctx[r.completion_tag];
			end
		end
		return o;
	endfunction

	// Random busy tag within the active range, -1 when none
	function automatic int pick_busy_tag();
		int busy[$];
		int i;
		for (i = 0; i < int'(usable_slots()); i++) begin
			if (!free_slots[i]) busy.insert(busy.size(), i);
		end
		if (busy.size() == 0) return -1;
		return busy[$urandom_range(0, busy.size() - 1)];
	endfunction

	function automatic itag_req_t random_req();
		itag_req_t r;
		r.req_type = 1'($urandom_range(0, 1));
		r.file_handle = 31'($urandom);
		r.is_write = 1'($urandom_range(0, 1));
		r.first_sector = 55'({$urandom, $urandom});
		r.end_sector = 55'({$urandom, $urandom});
		r.buffer_address = {$urandom, $urandom};
		r.request_context = $urandom;
		r.completion_tag = TAG_W'($urandom_range(0, 63));
		r.completion_result = {$urandom, $urandom};
		return r;
	endfunction

	function automatic itag_req_t issue_req(logic [30:0] handle, logic wr, logic [54:0] first,
			logic [54:0] last, logic [63:0] buf_addr, logic [31:0] ctx);
		itag_req_t r;
		r = random_req();
		r.req_type = REQ_ISSUE;
		r.file_handle = handle;
		r.is_write = wr;
		r.first_sector = first;
		r.end_sector = last;
		r.buffer_address = buf_addr;
		r.request_context = ctx;
		return r;
	endfunction

	function automatic itag_req_t retire_req(int tag, logic [63:0] result);
		itag_req_t r;
		r = random_req();
		r.req_type = REQ_COMPLETE;
		r.completion_tag = TAG_W'(tag);
		r.completion_result = result;
		return r;
	endfunction

	task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
	endtask

	// Offer one request, wait for the handshake, record its expected response
	task automatic send_request(itag_req_t item);
		if (gaps_on && burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (gaps_on) burst_left--;
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		rsp_due.insert(rsp_due.size(), resolve_tag_request(item));
	endtask

	// Stop offering and wait for every outstanding response
	task automatic settle();
		req_valid <= 1'b0;
		while (rsp_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_active_slots(int unsigned n);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= CFG_W'(n);
		@(posedge clk);
		cfg_we <= 1'b0;
		active_setting = CFG_W'(n);
		free_slots = slot_mask();
	endtask

	task automatic test_directed_cases();
		stall_mode = STALL_LIGHT;
		gaps_on = 1'b1;
		// zero-length transfer, then reversed range with all-ones fields
		send_request(issue_req('0, 1'b0, '0, '0, '0, '0));
		send_request(issue_req('1, 1'b1, '1, '0, 64'hFFFF_FFFF_FFFF_F000, '1));
		// misaligned buffers: lowest bit, highest in-page bit, all in-page bits
		send_request(issue_req(31'd7, 1'b0, 55'd8, 55'd16, 64'h1, 32'h11));
		send_request(issue_req(31'd7, 1'b1, 55'd8, 55'd16, 64'h800, 32'h22));
		send_request(issue_req(31'd7, 1'b1, 55'd8, 55'd16, 64'h8000_0000_0000_0FFF, 32'h33));
		// exact result, then a negative error code
		send_request(retire_req(0, 64'd0));
		send_request(retire_req(1, '1));
		// completion on a slot already freed and on one never used
		send_request(retire_req(1, 64'd0));
		send_request(retire_req(63, 64'd0));
		// widest forward span, retired with its exact byte count
		send_request(issue_req(31'h1234_5678, 1'b0, '0, '1, 64'h1000, 32'hCAFE_0001));
		send_request(retire_req(0, slot_bytes[0]));
		// small reversed span retired with the most negative result
		send_request(issue_req(31'd1, 1'b1, 55'd5, 55'd3, 64'h7FFF_F000, 32'hA5A5_A5A5));
		send_request(retire_req(0, 64'h8000_0000_0000_0000));
		// off-by-one result
		send_request(issue_req(31'd2, 1'b0, 55'd100, 55'd108, 64'h2000, 32'h5A5A_5A5A));
		send_request(retire_req(0, slot_bytes[0] + 64'd1));
		settle();
	endtask

	task automatic test_slot_limits();
		// single slot: full table, misaligned checked before fullness, tag above range
		program_active_slots(1);
		send_request(issue_req(31'd10, 1'b0, 55'd0, 55'd1, 64'h3000, 32'h1));
		send_request(issue_req(31'd11, 1'b1, 55'd0, 55'd1, 64'h4000, 32'h2));
		send_request(issue_req(31'd12, 1'b1, 55'd0, 55'd1, 64'h4010, 32'h3));
		send_request(retire_req(1, 64'd0));
		send_request(retire_req(0, slot_bytes[0]));
		// zero behaves like one
		program_active_slots(0);
		send_request(issue_req(31'd13, 1'b0, 55'd2, 55'd4, 64'h5000, 32'h4));
		send_request(issue_req(31'd14, 1'b0, 55'd2, 55'd4, 64'h6000, 32'h5));
		// fill three slots, then reprogram to drop them
		program_active_slots(3);
		repeat (4) send_request(issue_req(31'd15, 1'b1, 55'd9, 55'd1, 64'h7000, 32'h6));
		program_active_slots(127);
		send_request(retire_req(0, 64'd0));
		send_request(issue_req(31'd16, 1'b0, 55'd0, 55'd8, 64'h8000, 32'h7));
		send_request(retire_req(63, 64'd0));
		settle();
	endtask

	// Hold responses off long enough that the block backs up into its input
	task automatic test_full_backpressure();
		int tag;
		itag_req_t r;
		program_active_slots(64);
		gaps_on = 1'b0;
		stall_mode = STALL_NONE;
		hold_request <= ~hold_request;
		repeat (40) begin
			r = random_req();
			r.req_type = REQ_ISSUE;
			r.buffer_address = r.buffer_address & ~64'(PAGE_BYTES - 1);
			send_request(r);
		end
		hold_request <= ~hold_request;
		tag = pick_busy_tag();
		while (tag >= 0) begin
			send_request(retire_req(tag, slot_bytes[tag]));
			tag = pick_busy_tag();
		end
		settle();
	endtask

	task automatic test_random_traffic();
		int unsigned settings[8];
		int          p;
		int          k;
		int          busy;
		itag_req_t   r;
		settings = '{64, 3, 1, 0, 127, 64, 64, 16};
		settings[5] = $urandom_range(2, 63);
		for (p = 0; p < 8; p++) begin
			program_active_slots(settings[p]);
			stall_mode = (p % 4 == 3) ? STALL_NONE : stall_style_t'(p % 4);
			gaps_on = (p % 4 != 3);
			for (k = 0; k < PHASE_REQUESTS; k++) begin
				r = random_req();
				busy = pick_busy_tag();
				if (busy < 0 || $urandom_range(0, 99) < 55) begin
					r.req_type = REQ_ISSUE;
					if ($urandom_range(0, 9) != 0)
						r.buffer_address = r.buffer_address & ~64'(PAGE_BYTES - 1);
					if ($urandom_range(0, 1))
						r.end_sector = r.first_sector + 55'($urandom_range(0, 256));
				end else begin
					r.req_type = REQ_COMPLETE;
					if ($urandom_range(0, 4) != 0) r.completion_tag = TAG_W'(busy);
					case ($urandom_range(0, 3))
						0, 1: r.completion_result = slot_bytes[r.completion_tag];
						2: r.completion_result = -64'($urandom_range(1, 200));
						default: ;
					endcase
				end
				send_request(r);
			end
		end
		settle();
	endtask

	// Response side stall pattern, with an occasional long hold
	always @(posedge clk) begin
		beat++;
		if (hold_request != hold_ack) begin
			hold_ack = hold_request;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
				STALL_PATTERN: rsp_stall <= (beat % 7 < 2);
				default: rsp_stall <= 1'b0;
			endcase
		end
	end

	// Compare each delivered response with the oldest expectation
	always @(posedge clk) begin
		itag_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due.size() == 0) begin
				flag_mismatch("response with nothing expected", 64'(rsp.status), 64'd0);
			end else begin
				want = rsp_due.pop_front();
				if (rsp.status !== want.status)
					flag_mismatch("status", 64'(rsp.status), 64'(want.status));
				if (rsp.slot_tag !== want.slot_tag)
					flag_mismatch("slot_tag", 64'(rsp.slot_tag), 64'(want.slot_tag));
				if (rsp.byte_offset !== want.byte_offset)
					flag_mismatch("byte_offset", rsp.byte_offset, want.byte_offset);
				if (rsp.byte_count !== want.byte_count)
					flag_mismatch("byte_count", rsp.byte_count, want.byte_count);
				if (rsp.handle_out !== want.handle_out)
					flag_mismatch("handle_out", 64'(rsp.handle_out), 64'(want.handle_out));
				if (rsp.write_out !== want.write_out)
					flag_mismatch("write_out", 64'(rsp.write_out), 64'(want.write_out));
				if (rsp.buffer_out !== want.buffer_out)
					flag_mismatch("buffer_out", rsp.buffer_out, want.buffer_out);
				if (rsp.returned_context !== want.returned_context)
					flag_mismatch("returned_context", 64'(rsp.returned_context),
						64'(want.returned_context));
			end
		end
	end

	// Watchdog: too long with no handshake on either side
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_slot_limits();
		test_full_backpressure();
		test_random_traffic();
		settle();
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/itag_pkg.sv
design/itag_front.sv
design/itag_queue.sv
design/itag_back.sv
design/io_tag_allocator.sv
tb/io_tag_allocator_test.sv
